// File: hdl/windowed_pid_controller_defines.svh
// Assertion macros shared by the windowed PID controller RTL.
`ifndef WINDOWED_PID_CONTROLLER_DEFINES_SVH
`define WINDOWED_PID_CONTROLLER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WPID_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define WPID_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wpid_pkg.sv
// Shared constants and types for the windowed PID controller.
package wpid_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int DIFF_LAG      = 4;

    // Lag that is a multiple of the depth reads the oldest entry.
    localparam int LAG_MOD = DIFF_LAG % HISTORY_DEPTH;
    localparam int LAG_EFF = (LAG_MOD == 0) ? HISTORY_DEPTH : LAG_MOD;

    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int TOTAL_W = 24;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int LIMIT_W = 23;
    localparam int CFG_W   = 23;
    localparam int IDX_W   = 2;
    localparam int OUT_W   = 32;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_GAIN_P    = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I    = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D    = 2'd2;
    localparam logic [IDX_W-1:0] REG_SUM_LIMIT = 2'd3;

    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [GAIN_W-1:0]  t_gain;
    typedef logic signed [TOTAL_W-1:0] t_total;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    // Operands handed from the window to the multiply stages.
    typedef struct packed {
        t_err   err;
        t_total total;
        t_diff  diff;
    } t_stage;

    typedef struct packed {
        t_gain p;
        t_gain i;
        t_gain d;
    } t_gains;

    // Occupancy of the multiply stages.
    typedef struct packed {
        logic prod_full;
        logic out_full;
    } t_mac_status;

endpackage

// File: hdl/wpid_cell.sv
// One history cell: holds an error word and passes it to its neighbor.
module wpid_cell import wpid_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_err i_d,
    output t_err o_q
);

    t_err r_q;

    // Take the neighbor's word on each accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_load) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: hdl/wpid_window.sv
// Error history chain, clamped window sum and lagged difference.
module wpid_window import wpid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_err               i_error_sample,
    input  logic [LIMIT_W-1:0] i_sum_limit,
    output t_stage             o_stage
);

    t_err   w_cell [HISTORY_DEPTH];
    t_total r_total;
    t_stage r_stage;

    logic signed [TOTAL_W:0] w_sum;
    logic signed [TOTAL_W:0] w_lim;
    t_total                  n_total;
    t_diff                   n_diff;

    // Cell k holds the error from k+1 samples back.
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            wpid_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_load (i_load),
                .i_d    (i_error_sample),
                .o_q    (w_cell[k])
            );
        end else begin : g_body
            wpid_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_load (i_load),
                .i_d    (w_cell[k-1]),
                .o_q    (w_cell[k])
            );
        end
    end

    // Drop the oldest error, add the new one, clamp to the limit.
    always_comb begin
        w_lim = $signed({2'b00, i_sum_limit});
        w_sum = (TOTAL_W+1)'(r_total) - (TOTAL_W+1)'(w_cell[HISTORY_DEPTH-1])
              + (TOTAL_W+1)'(i_error_sample);
        if (w_sum > w_lim) begin
            n_total = TOTAL_W'(w_lim);
        end else if (w_sum < -w_lim) begin
            n_total = TOTAL_W'(-w_lim);
        end else begin
            n_total = TOTAL_W'(w_sum);
        end
        n_diff = DIFF_W'(i_error_sample) - DIFF_W'(w_cell[LAG_EFF-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_load) begin
            r_total <= n_total;
        end
    end

    // Hold the operands for the multiply stage.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage.err   <= i_error_sample;
            r_stage.total <= n_total;
            r_stage.diff  <= n_diff;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/wpid_mac.sv
// Gain multiplies, term sum and output register with stall control.
module wpid_mac import wpid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  t_stage            i_s1,
    input  t_gains            i_gains,
    input  logic              i_out_ready,
    output logic              o_s1_take,
    output logic              o_out_valid,
    output logic [OUT_W-1:0]  o_drive_value,
    output t_mac_status       o_status
);

    localparam int PP_W  = ERR_W + GAIN_W;
    localparam int PI_W  = TOTAL_W + GAIN_W;
    localparam int PD_W  = DIFF_W + GAIN_W;
    localparam int ACC_W = PI_W + 1;

    logic                    r_v2;
    logic                    r_v3;
    logic signed [PP_W-1:0]  r_pp;
    logic signed [PI_W-1:0]  r_pi;
    logic signed [PD_W-1:0]  r_pd;
    logic [OUT_W-1:0]        r_drive;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_s2_load;
    logic                    w_s3_load;

    assign w_s3_load = !r_v3 || i_out_ready;
    assign w_s2_load = !r_v2 || w_s3_load;

    // Advance the valid flags as far as the receiver allows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_s2_load) begin
                r_v2 <= i_s1_valid;
            end
            if (w_s3_load) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Register the three products.
    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_pp <= PP_W'(i_s1.err)   * PP_W'(i_gains.p);
            r_pi <= PI_W'(i_s1.total) * PI_W'(i_gains.i);
            r_pd <= PD_W'(i_s1.diff)  * PD_W'(i_gains.d);
        end
    end

    // Sum the terms; bits from eight up give the floor shift.
    assign w_acc = ACC_W'(r_pp) + ACC_W'(r_pi) + ACC_W'(r_pd);

    always_ff @(posedge i_clk) begin
        if (w_s3_load) begin
            r_drive <= w_acc[OUT_W+7:8];
        end
    end

    assign o_s1_take          = w_s2_load;
    assign o_out_valid        = r_v3;
    assign o_drive_value      = r_drive;
    assign o_status.prod_full = r_v2;
    assign o_status.out_full  = r_v3;

endmodule

// File: hdl/windowed_pid_controller.sv
// Windowed PID controller top level: config registers, input stage, checks.
//
// Input channel: i_in_valid / o_in_ready carry one signed error word per
// control tick on i_error_sample. Output channel: o_out_valid / i_out_ready
// carry the drive word o_drive_value = (P + I + D) >>> 8.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 gain_p, 1 gain_i, 2 gain_d, 3 sum_limit); write only while idle.
// Path: a word accepted into the window stage moves through the product
// register into the output register. Throughput: one word per cycle
// until a receiver stall has filled all stages, set by the window update
// (16-cell history chain plus clamp); the three multiplies share one
// register stage and the final sum feeds the output register.
// Reset: history and window sum clear to zero, gains to zero, sum_limit to
// its maximum; all stages empty.
// Receiver stall: the output word holds; the three stages fill, and
// o_in_ready drops only once all of them are full.
module windowed_pid_controller import wpid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_error_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_drive_value,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

`include "windowed_pid_controller_defines.svh"

    t_gains             r_gains;
    logic [LIMIT_W-1:0] r_sum_limit;
    logic               r_v1;
    logic               w_accept;
    logic               w_s1_take;
    t_stage             w_stage;
    t_mac_status        w_status;
    logic [OUT_W-1:0]   w_drive;

    // Write configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains     <= '0;
            r_sum_limit <= {LIMIT_W{1'b1}};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAIN_P:    r_gains.p   <= t_gain'(i_cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:    r_gains.i   <= t_gain'(i_cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:    r_gains.d   <= t_gain'(i_cfg_data[GAIN_W-1:0]);
                REG_SUM_LIMIT: r_sum_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !r_v1 || w_s1_take;
    assign w_accept   = i_in_valid && o_in_ready;

    // Track the window stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_in_ready) begin
            r_v1 <= i_in_valid;
        end
    end

    wpid_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_error_sample(i_error_sample),
        .i_sum_limit   (r_sum_limit),
        .o_stage       (w_stage)
    );

    wpid_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (r_v1),
        .i_s1         (w_stage),
        .i_gains      (r_gains),
        .i_out_ready  (i_out_ready),
        .o_s1_take    (w_s1_take),
        .o_out_valid  (o_out_valid),
        .o_drive_value(w_drive),
        .o_status     (w_status)
    );

    assign o_drive_value = $signed(w_drive);

    `WPID_ASSERT_SAME(a_ready_low_full, i_clk, i_rst_n, !o_in_ready, r_v1 && w_status.prod_full && o_out_valid, "input stalled with a free stage")
    `WPID_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, w_accept, r_v1, "accepted word not held in window stage")
    `WPID_ASSERT_NEXT(a_prod_moves_out, i_clk, i_rst_n, !o_out_valid && w_status.prod_full, o_out_valid, "product stage did not reach empty output")

endmodule
